@@ design/pld_pkg.sv @@
// Shared types and constants for the positional list block.
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_COUNT     = 3'd6
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_INS_RD  = 3'd1,
    S_INS_WR  = 3'd2,
    S_DEL_RD0 = 3'd3,
    S_DEL_CAP = 3'd4,
    S_DEL_RD  = 3'd5,
    S_DEL_WR  = 3'd6,
    S_DONE    = 3'd7
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ design/pld_ram.sv @@
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pld_ram (
  input  wire logic                       clk_i,
  input  wire pld_pkg::ram_req_t          req_i,
  output logic [pld_pkg::DATA_W-1:0]      rdata_o
);

  logic [pld_pkg::DATA_W-1:0] mem_q [pld_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

@@ design/positional_list_insert_delete.sv @@
// Top level of the bounded positional list with insert, delete and count operations.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps an ordered list of up to 16 signed 32-bit words in a small
// single-port-write, registered-read memory. Each input item names one
// operation and always yields exactly one result item with a status, the
// word removed by a successful delete (zero otherwise) and the entry count
// after the operation. Inserts and deletes move the entries behind the chosen
// slot one at a time through the memory port, with a read state and then a
// write state per moved entry and one index adder stepping the index pointer.
// A delete first reads and captures the removed word; count queries and
// rejected requests go straight to the result state.
// The input side is ready only while the sequencer is idle, and the result
// sits in an output register so a new item can be taken while it waits.
// No clearing pass is needed after reset: only entries below the count are read.

module positional_list_insert_delete (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [4:0] position, [36:5] value, [39:37] zero
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] kind
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] removed_value, [36:32] entry_count,
                                           // [39:37] zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  localparam int unsigned IW = pld_pkg::IDX_W;
  localparam int unsigned CW = pld_pkg::CNT_W;
  localparam int unsigned DW = pld_pkg::DATA_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(pld_pkg::DEPTH);

  pld_pkg::state_e  state_q, state_d;
  pld_pkg::op_e     op_q, op_d;
  pld_pkg::status_e stat_q, stat_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    slot_q, slot_d;
  logic [DW-1:0]    word_q, word_d;
  logic [DW-1:0]    removed_q, removed_d;

  logic             out_valid_q, out_valid_d;
  logic [CW-1:0]    out_count_q, out_count_d;
  logic [DW-1:0]    out_removed_q, out_removed_d;
  pld_pkg::status_e out_stat_q, out_stat_d;

  pld_pkg::ram_req_t ram_req;
  logic [DW-1:0]     ram_rdata;

  // Input fields.
  pld_pkg::kind_e   in_kind;
  logic [CW-1:0]    in_pos;
  logic [DW-1:0]    in_word;

  // The one shared index unit: step the pointer up or down by one.
  logic             alu_dec;
  logic [CW-1:0]    alu_sum;

  logic             accept;
  logic             load_out;

  assign in_kind = pld_pkg::kind_e'(s_axis_tuser);
  assign in_pos  = s_axis_tdata[CW-1:0];
  assign in_word = s_axis_tdata[CW +: DW];

  assign alu_sum = idx_q + (alu_dec ? {CW{1'b1}} : CW'(1));

  assign s_axis_tready = (state_q == pld_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  pld_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pld_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    stat_q        <= stat_d;
    idx_q         <= idx_d;
    slot_q        <= slot_d;
    word_q        <= word_d;
    removed_q     <= removed_d;
    out_count_q   <= out_count_d;
    out_removed_q <= out_removed_d;
    out_stat_q    <= out_stat_d;
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    stat_d        = stat_q;
    count_d       = count_q;
    idx_d         = idx_q;
    slot_d        = slot_q;
    word_d        = word_q;
    removed_d     = removed_q;
    out_valid_d   = out_valid_q;
    out_count_d   = out_count_q;
    out_removed_d = out_removed_q;
    out_stat_d    = out_stat_q;
    alu_dec       = 1'b1;
    load_out      = 1'b0;
    ram_req       = '{we: 1'b0, waddr: slot_q[IW-1:0], wdata: word_q,
                      raddr: alu_sum[IW-1:0]};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pld_pkg::S_IDLE: begin
        if (accept) begin
          op_d      = pld_pkg::OP_NONE;
          stat_d    = pld_pkg::STAT_OK;
          slot_d    = '0;
          word_d    = in_word;
          removed_d = '0;
          idx_d     = count_q;
          case (in_kind)
            pld_pkg::KIND_INS_FRONT, pld_pkg::KIND_INS_BACK, pld_pkg::KIND_INS_POS: begin
              // Full is checked before the position.
              if (count_q >= DEPTH_C) begin
                stat_d = pld_pkg::STAT_FULL;
              end else if (in_kind == pld_pkg::KIND_INS_FRONT) begin
                op_d = pld_pkg::OP_INS;
              end else if (in_kind == pld_pkg::KIND_INS_BACK) begin
                op_d   = pld_pkg::OP_INS;
                slot_d = count_q;
              end else if (in_pos != '0 &&
                           {1'b0, in_pos} <= ({1'b0, count_q} + (CW+1)'(1))) begin
                op_d   = pld_pkg::OP_INS;
                slot_d = in_pos - CW'(1);
              end else begin
                stat_d = pld_pkg::STAT_BADPOS;
              end
            end
            pld_pkg::KIND_DEL_FRONT, pld_pkg::KIND_DEL_BACK, pld_pkg::KIND_DEL_POS: begin
              // Empty is checked before the position.
              if (count_q == '0) begin
                stat_d = pld_pkg::STAT_EMPTY;
              end else if (in_kind == pld_pkg::KIND_DEL_FRONT) begin
                op_d = pld_pkg::OP_DEL;
              end else if (in_kind == pld_pkg::KIND_DEL_BACK) begin
                op_d   = pld_pkg::OP_DEL;
                slot_d = count_q - CW'(1);
              end else if (in_pos != '0 && in_pos <= count_q) begin
                op_d   = pld_pkg::OP_DEL;
                slot_d = in_pos - CW'(1);
              end else begin
                stat_d = pld_pkg::STAT_BADPOS;
              end
            end
            default: begin
              // Count query, and the unused kind code behaves the same way.
            end
          endcase
          case (op_d)
            pld_pkg::OP_INS: state_d = pld_pkg::S_INS_RD;
            pld_pkg::OP_DEL: state_d = pld_pkg::S_DEL_RD0;
            default:         state_d = pld_pkg::S_DONE;
          endcase
        end
      end

      pld_pkg::S_INS_RD: begin
        // Walk from the back toward the slot; at the slot drop in the new word.
        alu_dec = 1'b1;
        if (idx_q == slot_q) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = slot_q[IW-1:0];
          ram_req.wdata = word_q;
          state_d       = pld_pkg::S_DONE;
        end else begin
          ram_req.raddr = alu_sum[IW-1:0];
          state_d       = pld_pkg::S_INS_WR;
        end
      end

      pld_pkg::S_INS_WR: begin
        alu_dec       = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q[IW-1:0];
        ram_req.wdata = ram_rdata;
        idx_d         = alu_sum;
        state_d       = pld_pkg::S_INS_RD;
      end

      pld_pkg::S_DEL_RD0: begin
        ram_req.raddr = slot_q[IW-1:0];
        idx_d         = slot_q;
        state_d       = pld_pkg::S_DEL_CAP;
      end

      pld_pkg::S_DEL_CAP: begin
        removed_d = ram_rdata;
        state_d   = pld_pkg::S_DEL_RD;
      end

      pld_pkg::S_DEL_RD: begin
        // Pull the following entry forward until the old back is reached.
        alu_dec = 1'b0;
        if (alu_sum >= count_q) begin
          state_d = pld_pkg::S_DONE;
        end else begin
          ram_req.raddr = alu_sum[IW-1:0];
          state_d       = pld_pkg::S_DEL_WR;
        end
      end

      pld_pkg::S_DEL_WR: begin
        alu_dec       = 1'b0;
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q[IW-1:0];
        ram_req.wdata = ram_rdata;
        idx_d         = alu_sum;
        state_d       = pld_pkg::S_DEL_RD;
      end

      pld_pkg::S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          case (op_q)
            pld_pkg::OP_INS: count_d = count_q + CW'(1);
            pld_pkg::OP_DEL: count_d = count_q - CW'(1);
            default:         count_d = count_q;
          endcase
          out_valid_d   = 1'b1;
          out_count_d   = count_d;
          out_removed_d = removed_q;
          out_stat_d    = stat_q;
          state_d       = pld_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pld_pkg::S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_removed_q};
  assign m_axis_tuser  = out_stat_q;

  // The held count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("held count exceeds capacity");

  // A full report is only ever given with the list at capacity.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && stat_q == pld_pkg::STAT_FULL) |-> (count_q == DEPTH_C))
    else $error("full status with room left");

  // An empty report is only ever given with no entries held.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && stat_q == pld_pkg::STAT_EMPTY) |-> (count_q == '0))
    else $error("empty status with entries held");

  // Writes stay within the occupied range plus one slot for an insert.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> ({1'b0, ram_req.waddr} <= (CW+1)'(count_q)))
    else $error("entry write beyond list end");

endmodule

`default_nettype wire
